// ===== sv/first_fit_partition_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// first_fit_partition_allocator macros
// Assertion helpers for the partition allocator, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define FFPA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffpa check failed");
`define FFPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffpa check failed");
`else
`define FFPA_ASSERT_IMPLY(label, ante, cons)
`define FFPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Port widths and command codes of the partition allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int CMD_W   = 1;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 16;
    localparam int FRAG_W  = 16;
    localparam int COUNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

endpackage

// ===== sv/ffpa_ram.sv =====
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/first_fit_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_partition_allocator
// Load: writes the entry and clears its used mark, no result. Allocate: checks
// the first min(count, MAX_PARTITIONS) entries in turn from zero while busy and
// strobes a grant for the first unused one that holds the request, else a refusal.
// Results cannot be stalled. Reset clears used marks and count, not the RAM.
// ----------------------------------------------------------------------------
`include "first_fit_partition_allocator_macros.svh"

module first_fit_partition_allocator #(
    parameter int MAX_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ffpa_pkg::CMD_W-1:0]    i_cmd,
    input  logic [ffpa_pkg::INDEX_W-1:0]  i_partition_index,
    input  logic [ffpa_pkg::VALUE_W-1:0]  i_size_value,
    output logic                          o_result_valid,
    output logic                          o_granted,
    output logic [ffpa_pkg::INDEX_W-1:0]  o_granted_index,
    output logic [ffpa_pkg::FRAG_W-1:0]   o_fragment,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffpa_pkg::COUNT_W-1:0]  i_cfg_data
);

    import ffpa_pkg::*;

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int LIM_W = ($clog2(MAX_PARTITIONS + 1) > COUNT_W) ?
                           $clog2(MAX_PARTITIONS + 1) : COUNT_W + 1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state                r_state;
    logic [MAX_PARTITIONS-1:0] r_used;
    logic [COUNT_W-1:0]    r_count;
    logic [SIZE_BITS-1:0]  r_req;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic [IDX_W-1:0]      r_last;
    logic                  r_out_valid;
    logic                  r_out_granted;
    logic [IDX_W-1:0]      r_out_idx;
    logic [FRAG_W-1:0]     r_out_frag;

    logic                  accept;
    logic                  is_load;
    logic                  load_in_range;
    logic [IDX_W-1:0]      load_idx;
    logic [LIM_W-1:0]      count_ext;
    logic [LIM_W-1:0]      lim;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_raddr;
    logic [SIZE_BITS-1:0]  ram_rdata;
    logic [SIZE_BITS-1:0]  frag_full;
    logic                  hit;

    assign busy          = (r_state == ST_SCAN);
    assign accept        = start && !busy;
    assign is_load       = (i_cmd == CMD_LOAD);
    assign load_in_range = (LIM_W'(i_partition_index) < LIM_W'(MAX_PARTITIONS));
    assign load_idx      = IDX_W'(i_partition_index);
    assign count_ext     = LIM_W'(r_count);
    assign lim           = (count_ext > LIM_W'(MAX_PARTITIONS)) ?
                           LIM_W'(MAX_PARTITIONS) : count_ext;
    assign ram_we        = accept && is_load && load_in_range;
    assign ram_raddr     = (r_state == ST_SCAN) ? IDX_W'(r_cmp_idx + 1'b1) : '0;
    assign hit           = !r_used[r_cmp_idx] && (ram_rdata >= r_req);
    assign frag_full     = ram_rdata - r_req;

    ffpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTITIONS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (load_idx),
        .i_wdata (SIZE_BITS'(i_size_value)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (is_load) begin
                            if (load_in_range) begin
                                r_used[load_idx] <= 1'b0;
                            end
                        end else begin
                            r_req     <= SIZE_BITS'(i_size_value);
                            r_cmp_idx <= '0;
                            r_last    <= IDX_W'(lim - 1'b1);
                            if (lim == '0) begin
                                r_out_valid   <= 1'b1;
                                r_out_granted <= 1'b0;
                                r_out_idx     <= '0;
                                r_out_frag    <= '0;
                            end else begin
                                r_state <= ST_SCAN;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (hit) begin
                        r_used[r_cmp_idx] <= 1'b1;
                        r_out_valid       <= 1'b1;
                        r_out_granted     <= 1'b1;
                        r_out_idx         <= r_cmp_idx;
                        r_out_frag        <= FRAG_W'(frag_full);
                        r_state           <= ST_IDLE;
                    end else if (r_cmp_idx == r_last) begin
                        r_out_valid   <= 1'b1;
                        r_out_granted <= 1'b0;
                        r_out_idx     <= '0;
                        r_out_frag    <= '0;
                        r_state       <= ST_IDLE;
                    end else begin
                        r_cmp_idx <= r_cmp_idx + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_result_valid  = r_out_valid;
    assign o_granted       = r_out_granted;
    assign o_granted_index = INDEX_W'(r_out_idx);
    assign o_fragment      = r_out_frag;

    `FFPA_ASSERT_IMPLY(a_scan_in_range, r_state == ST_SCAN, r_cmp_idx <= r_last)
    `FFPA_ASSERT_IMPLY(a_grant_marks_used, o_result_valid && o_granted, r_used[r_out_idx])
    `FFPA_ASSERT_IMPLY(a_no_grant_zero, r_out_valid && !r_out_granted, {r_out_idx, r_out_frag} == '0)
    `FFPA_ASSERT_NEXT(a_alloc_goes_busy, accept && !is_load && (lim != '0), busy && !o_result_valid)

endmodule

// ===== tb/sv/first_fit_partition_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_tb
// Drives load and allocate words into the first-fit allocator, predicts each
// grant from a local copy of the partition table and the scan count, and
// checks every result strobe against the oldest predicted grant. The scan
// count is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_tb;

    import ffpa_pkg::*;

    localparam int PARTS       = 16;
    localparam int SETTLE      = 24;
    localparam int TAIL_CYCLES = 40;
    localparam int RAND_ITEMS  = 1280;
    localparam int QUIET_FROM  = 1100;

    typedef struct {
        bit                 is_cfg;
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] size;
        logic [COUNT_W-1:0] count;
        int                 gap;
    } stim_word_t;

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] idx;
        logic [FRAG_W-1:0]  frag;
    } grant_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     i_cmd = CMD_LOAD;
    logic [INDEX_W-1:0]   i_partition_index = '0;
    logic [VALUE_W-1:0]   i_size_value = '0;
    logic                 o_result_valid;
    logic                 o_granted;
    logic [INDEX_W-1:0]   o_granted_index;
    logic [FRAG_W-1:0]    o_fragment;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_data = '0;

    stim_word_t           word_q[$];
    grant_t               grant_q[$];

    logic [VALUE_W-1:0]   part_size [PARTS];
    bit                   part_taken [PARTS];
    logic [COUNT_W-1:0]   scan_count = '0;

    int                   hold_cnt = 0;
    int                   settle_cnt = 0;
    int                   mismatch_cnt = 0;
    int                   n_loads = 0;
    int                   n_allocs = 0;
    int                   n_grants = 0;
    int                   n_cfg = 0;

    stim_word_t           cur_word;
    bit                   next_start;
    bit                   next_cfg;

    first_fit_partition_allocator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_partition_index (i_partition_index),
        .i_size_value      (i_size_value),
        .o_result_valid    (o_result_valid),
        .o_granted         (o_granted),
        .o_granted_index   (o_granted_index),
        .o_fragment        (o_fragment),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("first_fit_partition_allocator: mismatch");
        $finish;
    end

    function automatic int pick_gap(bit quiet);
        if (quiet) return 0;
        return ($urandom_range(0, 99) < 30) ? int'($urandom_range(1, 5)) : 0;
    endfunction

    task automatic push_item(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                             logic [VALUE_W-1:0] size, int gap);
        stim_word_t w;
        w.is_cfg = 1'b0;
        w.cmd    = cmd;
        w.idx    = idx;
        w.size   = size;
        w.count  = '0;
        w.gap    = gap;
        word_q.push_back(w);
    endtask

    task automatic push_count(logic [COUNT_W-1:0] count, int gap);
        stim_word_t w;
        w.is_cfg = 1'b1;
        w.cmd    = CMD_LOAD;
        w.idx    = '0;
        w.size   = '0;
        w.count  = count;
        w.gap    = gap;
        word_q.push_back(w);
    endtask

    // Scan unused partitions from zero and take the first that holds the request.
    function automatic grant_t first_fit_grant(logic [VALUE_W-1:0] req);
        grant_t g;
        int     lim;
        g   = '0;
        lim = (int'(scan_count) > PARTS) ? PARTS : int'(scan_count);
        for (int n = 0; n < lim; n++) begin
            if (!part_taken[n] && part_size[n] >= req) begin
                part_taken[n] = 1'b1;
                g.granted     = 1'b1;
                g.idx         = INDEX_W'(n);
                g.frag        = part_size[n] - req;
                break;
            end
        end
        return g;
    endfunction

    function automatic logic [VALUE_W-1:0] load_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 60) return VALUE_W'($urandom_range(0, 8191));
        return VALUE_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [VALUE_W-1:0] request_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        if (r < 25) return VALUE_W'($urandom_range(0, 65535));
        return VALUE_W'($urandom_range(0, 4095));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            hold_cnt    = 0;
            settle_cnt  = 0;
        end else begin
            if (start && !busy) begin
                cur_word   = word_q.pop_front();
                settle_cnt = 0;
                if (cur_word.cmd == CMD_LOAD) begin
                    part_size[cur_word.idx]  = cur_word.size;
                    part_taken[cur_word.idx] = 1'b0;
                    n_loads++;
                end else begin
                    grant_q.push_back(first_fit_grant(cur_word.size));
                    if (grant_q[$].granted) n_grants++;
                    n_allocs++;
                end
                hold_cnt = (word_q.size() > 0) ? word_q[0].gap : 0;
            end else if (i_cfg_valid && o_cfg_ready) begin
                cur_word   = word_q.pop_front();
                scan_count = cur_word.count;
                settle_cnt = 0;
                n_cfg++;
                hold_cnt = (word_q.size() > 0) ? word_q[0].gap : 0;
            end else if (o_result_valid) begin
                settle_cnt = 0;
            end else if (settle_cnt < 1000) begin
                settle_cnt++;
            end

            next_start = 1'b0;
            next_cfg   = 1'b0;
            if (hold_cnt > 0) begin
                hold_cnt--;
            end else if (word_q.size() > 0) begin
                if (!word_q[0].is_cfg) begin
                    next_start        = 1'b1;
                    i_cmd             <= word_q[0].cmd;
                    i_partition_index <= word_q[0].idx;
                    i_size_value      <= word_q[0].size;
                end else if (settle_cnt >= SETTLE && grant_q.size() == 0) begin
                    next_cfg   = 1'b1;
                    i_cfg_data <= word_q[0].count;
                end
            end
            start       <= next_start;
            i_cfg_valid <= next_cfg;
        end
    end

    always @(posedge i_clk) begin
        grant_t want;
        grant_t got;
        if (i_rst_n && o_result_valid) begin
            got = {o_granted, o_granted_index, o_fragment};
            if (grant_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected grant word: granted %b index %0d fragment %0d",
                             got.granted, got.idx, got.frag);
            end else begin
                want = grant_q.pop_front();
                if (got.granted !== want.granted || got.idx !== want.idx ||
                    got.frag !== want.frag) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("grant word differs: exp %b/%0d/%0d got %b/%0d/%0d",
                                 want.granted, want.idx, want.frag,
                                 got.granted, got.idx, got.frag);
                end
            end
        end
    end

    initial begin
        int n_rand;
        int phase;
        int batch;
        int cnt_pick;
        bit quiet;

        // Zero count after reset: refuse without touching the table.
        push_item(CMD_ALLOC, 4'hF, 16'hFFFF, 0);
        for (int p = 0; p < PARTS; p++) begin
            case (p)
                0: push_item(CMD_LOAD, INDEX_W'(p), 16'd100, pick_gap(0));
                1: push_item(CMD_LOAD, INDEX_W'(p), 16'd0, pick_gap(0));
                2: push_item(CMD_LOAD, INDEX_W'(p), 16'hFFFF, pick_gap(0));
                3: push_item(CMD_LOAD, INDEX_W'(p), 16'd50, pick_gap(0));
                4: push_item(CMD_LOAD, INDEX_W'(p), 16'hAAAA, pick_gap(0));
                5: push_item(CMD_LOAD, INDEX_W'(p), 16'h5555, pick_gap(0));
                default: push_item(CMD_LOAD, INDEX_W'(p), VALUE_W'(200 + 37 * p), pick_gap(0));
            endcase
        end
        // Count beyond the table scans all partitions.
        push_count(5'd31, 0);
        push_item(CMD_ALLOC, 4'h0, 16'hFFFF, pick_gap(0));
        push_item(CMD_ALLOC, 4'hA, 16'd0, pick_gap(0));
        push_item(CMD_ALLOC, 4'h5, 16'd0, pick_gap(0));
        push_item(CMD_ALLOC, 4'hF, 16'hFFFF, pick_gap(0));
        push_item(CMD_ALLOC, 4'h3, 16'd60, pick_gap(0));
        push_count(5'd0, 0);
        push_item(CMD_ALLOC, 4'h1, 16'd1, pick_gap(0));
        push_count(5'd1, 0);
        push_item(CMD_ALLOC, 4'h2, 16'd0, pick_gap(0));
        // Reload clears the used mark.
        push_item(CMD_LOAD, 4'h0, 16'hFFFF, pick_gap(0));
        push_item(CMD_ALLOC, 4'h7, 16'hFFFF, pick_gap(0));

        n_rand = 0;
        phase  = 0;
        while (n_rand < RAND_ITEMS) begin
            quiet = (n_rand >= QUIET_FROM);
            case (phase % 6)
                0: cnt_pick = PARTS;
                1: cnt_pick = $urandom_range(17, 31);
                2: cnt_pick = 1;
                3: cnt_pick = 0;
                4: cnt_pick = $urandom_range(2, 15);
                default: cnt_pick = $urandom_range(0, 31);
            endcase
            push_count(COUNT_W'(cnt_pick), pick_gap(quiet));
            batch = $urandom_range(30, 90);
            for (int j = 0; j < batch; j++) begin
                quiet = (n_rand + j >= QUIET_FROM);
                if ($urandom_range(0, 99) < 35)
                    push_item(CMD_LOAD, INDEX_W'($urandom_range(0, PARTS - 1)),
                              load_size(), pick_gap(quiet));
                else
                    push_item(CMD_ALLOC, INDEX_W'($urandom_range(0, PARTS - 1)),
                              request_size(), pick_gap(quiet));
            end
            n_rand += batch;
            phase++;
        end

        while (word_q.size() != 0 || grant_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d loads and %0d allocations over %0d scan-count settings",
                 n_loads, n_allocs, n_cfg);
        $display("%0d allocations granted, %0d refused", n_grants, n_allocs - n_grants);
        if (mismatch_cnt == 0) begin
            $display("first_fit_partition_allocator: match");
        end else begin
            $display("%0d grant words differed", mismatch_cnt);
            $display("first_fit_partition_allocator: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ffpa_pkg.sv
sv/ffpa_ram.sv
sv/first_fit_partition_allocator.sv
tb/sv/first_fit_partition_allocator_tb.sv
